>>> src/m4i_pkg.sv
// ----------------------------------------------------------------------------
// m4i_pkg
// Shared types, constants and element addressing for the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package m4i_pkg;

    localparam int M4I_ELEMENT_WIDTH = 32;
    localparam int M4I_FRACTION_BITS = 16;
    localparam int M4I_DET_FRACTION  = 32;
    localparam int M4I_DET_WIDTH     = 64;
    localparam int M4I_LIMBS         = 4;

    // top limb index of the multiplicand, per operand kind
    localparam logic [1:0] LIMB_TOP_ELEM  = 2'd0;
    localparam logic [1:0] LIMB_TOP_MINOR = 2'd2;
    localparam logic [1:0] LIMB_TOP_ADJ   = 2'd3;

    // cofactor term phases
    localparam logic [1:0] PH_MINOR_A = 2'd0;
    localparam logic [1:0] PH_MINOR_B = 2'd1;
    localparam logic [1:0] PH_TERM    = 2'd2;

    localparam logic [1:0] TERM_LAST  = 2'd2;
    localparam logic [1:0] LIMB_LAST  = 2'd3;
    localparam logic [3:0] ELEM_LAST  = 4'd15;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CRD,
        ST_CMUL,
        ST_CWAIT,
        ST_DETFIN,
        ST_QRD,
        ST_QSTART,
        ST_QWAIT,
        ST_OUT
    } m4i_state_t;

    typedef struct packed {
        logic       start;
        logic [1:0] top_limb;
    } m4i_mac_ctl_t;

    typedef struct packed {
        logic [3:0] a0;
        logic [3:0] a1;
    } m4i_addr_t;

    // element addresses for cofactor k, term t, phase ph
    function automatic m4i_addr_t m4i_op_addr(input logic [3:0] k, input logic [1:0] t,
                                              input logic [1:0] ph);
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] r0;
        logic [1:0] r1;
        logic [1:0] r2;
        logic [1:0] c0;
        logic [1:0] c1;
        logic [1:0] c2;
        logic [1:0] ec;
        logic [1:0] ca;
        logic [1:0] cb;
        m4i_addr_t  a;
        r  = k[3:2];
        c  = k[1:0];
        r0 = (c == 2'd0) ? 2'd1 : 2'd0;
        r1 = (c <= 2'd1) ? 2'd2 : 2'd1;
        r2 = (c <= 2'd2) ? 2'd3 : 2'd2;
        c0 = (r == 2'd0) ? 2'd1 : 2'd0;
        c1 = (r <= 2'd1) ? 2'd2 : 2'd1;
        c2 = (r <= 2'd2) ? 2'd3 : 2'd2;
        ec = (t == 2'd0) ? c0 : ((t == 2'd1) ? c1 : c2);
        ca = (t == 2'd0) ? c1 : c0;
        cb = (t == 2'd2) ? c1 : c2;
        case (ph)
            PH_MINOR_A:
            begin
                a.a0 = {r1, ca};
                a.a1 = {r2, cb};
            end
            PH_MINOR_B:
            begin
                a.a0 = {r1, cb};
                a.a1 = {r2, ca};
            end
            default:
            begin
                a.a0 = {r0, ec};
                a.a1 = {r0, ec};
            end
        endcase
        return a;
    endfunction

endpackage

>>> src/m4i_if.sv
// ----------------------------------------------------------------------------
// m4i interfaces
// Element input channel and result output channel, valid/ready.
// ----------------------------------------------------------------------------
interface m4i_elem_if
    import m4i_pkg::*;
#(
    parameter int ELEMENT_WIDTH = M4I_ELEMENT_WIDTH
) ();
    logic                     valid;
    logic                     ready;
    logic [ELEMENT_WIDTH-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface m4i_result_if
    import m4i_pkg::*;
#(
    parameter int ELEMENT_WIDTH = M4I_ELEMENT_WIDTH
) ();
    logic                     valid;
    logic                     ready;
    logic [ELEMENT_WIDTH-1:0] inverse_value;
    logic [3:0]               element_index;
    logic [M4I_DET_WIDTH-1:0] determinant_value;
    logic                     singular_flag;
    logic                     overflow_flag;
    logic                     last_flag;

    modport source (output valid, output inverse_value, output element_index,
                    output determinant_value, output singular_flag,
                    output overflow_flag, output last_flag, input ready);
    modport sink   (input valid, input inverse_value, input element_index,
                    input determinant_value, input singular_flag,
                    input overflow_flag, input last_flag, output ready);
endinterface

>>> src/m4i_mac.sv
// ----------------------------------------------------------------------------
// m4i_mac
// Limb-serial signed multiplier: element times a wide multiplicand, one
// W x (W+1) product per cycle, most significant limb first.
// ----------------------------------------------------------------------------
module m4i_mac
    import m4i_pkg::*;
#(
    parameter int ELEMENT_WIDTH = M4I_ELEMENT_WIDTH
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  m4i_mac_ctl_t                               ctl,
    input  logic [ELEMENT_WIDTH-1:0]                   a,
    input  logic [M4I_LIMBS*ELEMENT_WIDTH-1:0]         b,
    output logic [(M4I_LIMBS+1)*ELEMENT_WIDTH+1:0]     prod,
    output logic                                       done
);
    localparam int W  = ELEMENT_WIDTH;
    localparam int BW = M4I_LIMBS * W;
    localparam int PW = (M4I_LIMBS + 1) * W + 2;

    logic          busy_reg;
    logic          mvalid_reg;
    logic          mlast_reg;
    logic          done_reg;
    logic [1:0]    idx_reg;
    logic [1:0]    top_reg;
    logic [W-1:0]  a_reg;
    logic [BW-1:0] b_reg;
    logic [2*W:0]  mul_reg;
    logic [PW-1:0] sum_reg;

    logic [W-1:0]  limb;
    logic          ext;
    logic [2*W:0]  mul_next;
    logic [PW-1:0] sum_next;

    always_comb
    begin
        limb     = b_reg[idx_reg*W +: W];
        ext      = (idx_reg == top_reg) & limb[W-1];
        mul_next = $signed(a_reg) * $signed({ext, limb});
        sum_next = (sum_reg << W) + {{(PW-2*W-1){mul_reg[2*W]}}, mul_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            mlast_reg  <= 1'b0;
            done_reg   <= 1'b0;
            idx_reg    <= 2'd0;
            top_reg    <= 2'd0;
        end
        else
        begin
            mvalid_reg <= busy_reg;
            mlast_reg  <= busy_reg && (idx_reg == 2'd0);
            done_reg   <= mvalid_reg && mlast_reg;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= ctl.top_limb;
                top_reg  <= ctl.top_limb;
            end
            else if (busy_reg)
            begin
                if (idx_reg == 2'd0)
                    busy_reg <= 1'b0;
                else
                    idx_reg <= idx_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            sum_reg <= '0;
        end
        else if (mvalid_reg)
            sum_reg <= sum_next;
        if (busy_reg)
            mul_reg <= mul_next;
    end

    assign prod = sum_reg;
    assign done = done_reg;

endmodule

>>> src/m4i_div.sv
// ----------------------------------------------------------------------------
// m4i_div
// Radix-2 restoring divider, W+1 quotient bits, one bit per cycle.
// ----------------------------------------------------------------------------
module m4i_div
    import m4i_pkg::*;
#(
    parameter int ELEMENT_WIDTH = M4I_ELEMENT_WIDTH,
    parameter int NUM_WIDTH     = 4 * M4I_ELEMENT_WIDTH,
    parameter int DEN_WIDTH     = 4 * M4I_ELEMENT_WIDTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [NUM_WIDTH-1:0]     num,
    input  logic [DEN_WIDTH-1:0]     den,
    output logic [ELEMENT_WIDTH:0]   quot,
    output logic                     done
);
    localparam int W  = ELEMENT_WIDTH;
    localparam int RW = (NUM_WIDTH > DEN_WIDTH + W + 1) ? NUM_WIDTH : DEN_WIDTH + W + 1;
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] dsh_reg;
    logic [W:0]    q_reg;

    logic          ge;

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= RW'(num);
            dsh_reg <= RW'({den, {W{1'b0}}});
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[W-1:0], ge};
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

>>> src/matrix4_inverse.sv
// ----------------------------------------------------------------------------
// matrix4_inverse
// 4x4 matrix inverse by adjugate, signed fixed point.
// ----------------------------------------------------------------------------
// Usage: send 16 words on element, row-major, signed Q16.16 by default.
// After the sixteenth word the block computes the 16 cofactors and the exact
// determinant, then returns 16 words on result, row-major: the inverse
// element (saturated, truncated toward zero), its index, the determinant in
// Q32.32 (floored, saturated), singular, overflow and last flags.
// element.ready is high only while loading; a new matrix is taken once the
// last result word has been accepted.
// Each cofactor is nine multiply passes through one limb-serial multiplier,
// the determinant is summed on the same multiplier, and each quotient takes
// one run of the radix-2 divider. Operands live in two small synchronous
// memories (matrix and cofactors) with registered reads.
// A stalled result holds the output register and the whole block waits.
// Reset returns to loading at element 0; memory contents are not cleared.
// ----------------------------------------------------------------------------
module matrix4_inverse
    import m4i_pkg::*;
#(
    parameter int ELEMENT_WIDTH = M4I_ELEMENT_WIDTH,
    parameter int FRACTION_BITS = M4I_FRACTION_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    m4i_elem_if.sink      element,
    m4i_result_if.source  result
);
    localparam int W         = ELEMENT_WIDTH;
    localparam int F         = FRACTION_BITS;
    localparam int AW        = 3 * W + 2;
    localparam int M2W       = 2 * W + 2;
    localparam int ACCW      = 4 * W + 4;
    localparam int BW        = M4I_LIMBS * W;
    localparam int PW        = (M4I_LIMBS + 1) * W + 2;
    localparam int NW        = AW + 2 * F;
    localparam int DET_SHIFT = 4 * F - M4I_DET_FRACTION;
    localparam int DW        = M4I_DET_WIDTH;

    m4i_state_t state_reg, state_next;
    logic [3:0] load_cnt_reg, load_cnt_next;
    logic [3:0] k_reg, k_next;
    logic [1:0] t_reg, t_next;
    logic [1:0] ph_reg, ph_next;
    logic       det_mode_reg, det_mode_next;
    logic       out_valid_reg, out_valid_next;

    logic [M2W-1:0] acc2_reg, acc2_next;
    logic [AW-1:0]  acc3_reg, acc3_next;
    logic [ACCW-1:0] det_reg, det_next;
    logic [ACCW-1:0] dmag_reg, dmag_next;
    logic           dneg_reg, dneg_next;
    logic           sing_reg, sing_next;
    logic [DW-1:0]  det_out_reg, det_out_next;
    logic           det_sat_reg, det_sat_next;
    logic           qneg_reg, qneg_next;
    logic [W-1:0]   inv_reg, inv_next;
    logic [3:0]     idx_reg, idx_next;
    logic           ovf_reg, ovf_next;
    logic           last_reg, last_next;

    logic [W-1:0]  mat_mem [16];
    logic [AW-1:0] adj_mem [16];
    logic [W-1:0]  mrd0_reg;
    logic [W-1:0]  mrd1_reg;
    logic [AW-1:0] adj_rd_reg;

    logic [3:0]    ra0;
    logic [3:0]    ra1;
    logic [3:0]    adj_ra;
    logic          adj_we;
    logic [AW-1:0] adj_wdata;
    m4i_addr_t     op_addr;

    m4i_mac_ctl_t  mac_ctl;
    logic [BW-1:0] mac_b;
    logic [PW-1:0] mac_prod;
    logic          mac_done;

    logic          div_start;
    logic [NW-1:0] div_num;
    logic [W:0]    quot;
    logic          div_done;

    logic [AW-1:0]   acc3_base;
    logic            term_sub;
    logic [ACCW-1:0] dq;
    logic            dq_sat;
    logic [AW-1:0]   adj_abs;
    logic            q_sat;

    m4i_mac #(.ELEMENT_WIDTH(W)) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mrd0_reg),
        .b     (mac_b),
        .prod  (mac_prod),
        .done  (mac_done)
    );

    m4i_div #(.ELEMENT_WIDTH(W), .NUM_WIDTH(NW), .DEN_WIDTH(ACCW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dmag_reg),
        .quot  (quot),
        .done  (div_done)
    );

    // memories
    always_ff @(posedge clk)
    begin
        if (element.valid && element.ready)
            mat_mem[load_cnt_reg] <= element.element_value;
        if (adj_we)
            adj_mem[k_reg] <= adj_wdata;
        mrd0_reg   <= mat_mem[ra0];
        mrd1_reg   <= mat_mem[ra1];
        adj_rd_reg <= adj_mem[adj_ra];
    end

    // addressing and operand selection
    always_comb
    begin
        op_addr = m4i_op_addr(k_reg, t_reg, ph_reg);
        if (det_mode_reg)
        begin
            ra0    = {2'b00, k_reg[1:0]};
            ra1    = op_addr.a1;
            adj_ra = {k_reg[1:0], 2'b00};
        end
        else
        begin
            ra0    = op_addr.a0;
            ra1    = op_addr.a1;
            adj_ra = k_reg;
        end
        if (det_mode_reg)
        begin
            mac_b            = {{(BW-AW){adj_rd_reg[AW-1]}}, adj_rd_reg};
            mac_ctl.top_limb = LIMB_TOP_ADJ;
        end
        else if (ph_reg == PH_TERM)
        begin
            mac_b            = {{(BW-M2W){acc2_reg[M2W-1]}}, acc2_reg};
            mac_ctl.top_limb = LIMB_TOP_MINOR;
        end
        else
        begin
            mac_b            = {{(BW-W){mrd1_reg[W-1]}}, mrd1_reg};
            mac_ctl.top_limb = LIMB_TOP_ELEM;
        end
        mac_ctl.start = (state_reg == ST_CMUL);

        acc3_base = (t_reg == 2'd0) ? '0 : acc3_reg;
        term_sub  = (t_reg == 2'd1) ^ k_reg[2] ^ k_reg[0];
        adj_wdata = term_sub ? acc3_base - mac_prod[AW-1:0] : acc3_base + mac_prod[AW-1:0];

        dq     = $unsigned($signed(det_reg) >>> DET_SHIFT);
        dq_sat = !((&dq[ACCW-1:DW-1]) || !(|dq[ACCW-1:DW-1]));

        adj_abs = adj_rd_reg[AW-1] ? '0 - adj_rd_reg : adj_rd_reg;
        div_num = {adj_abs, {(2*F){1'b0}}};

        if (qneg_reg)
            q_sat = quot[W] | (quot[W-1] & (|quot[W-2:0]));
        else
            q_sat = quot[W] | quot[W-1];
    end

    // control
    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        ph_next        = ph_reg;
        det_mode_next  = det_mode_reg;
        out_valid_next = out_valid_reg;
        acc2_next      = acc2_reg;
        acc3_next      = acc3_reg;
        det_next       = det_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        sing_next      = sing_reg;
        det_out_next   = det_out_reg;
        det_sat_next   = det_sat_reg;
        qneg_next      = qneg_reg;
        inv_next       = inv_reg;
        idx_next       = idx_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        adj_we         = 1'b0;
        div_start      = 1'b0;
        element.ready  = (state_reg == ST_LOAD);

        case (state_reg)
            ST_LOAD:
            begin
                if (element.valid)
                begin
                    load_cnt_next = load_cnt_reg + 4'd1;
                    if (load_cnt_reg == ELEM_LAST)
                    begin
                        k_next        = '0;
                        t_next        = '0;
                        ph_next       = PH_MINOR_A;
                        det_mode_next = 1'b0;
                        state_next    = ST_CRD;
                    end
                end
            end
            ST_CRD:
                state_next = ST_CMUL;
            ST_CMUL:
                state_next = ST_CWAIT;
            ST_CWAIT:
            begin
                if (mac_done)
                begin
                    state_next = ST_CRD;
                    if (det_mode_reg)
                    begin
                        det_next = det_reg + mac_prod[ACCW-1:0];
                        k_next   = k_reg + 4'd1;
                        if (k_reg[1:0] == LIMB_LAST)
                            state_next = ST_DETFIN;
                    end
                    else
                    begin
                        case (ph_reg)
                            PH_MINOR_A:
                            begin
                                acc2_next = mac_prod[M2W-1:0];
                                ph_next   = PH_MINOR_B;
                            end
                            PH_MINOR_B:
                            begin
                                acc2_next = acc2_reg - mac_prod[M2W-1:0];
                                ph_next   = PH_TERM;
                            end
                            default:
                            begin
                                acc3_next = adj_wdata;
                                ph_next   = PH_MINOR_A;
                                if (t_reg == TERM_LAST)
                                begin
                                    adj_we = 1'b1;
                                    t_next = '0;
                                    k_next = k_reg + 4'd1;
                                    if (k_reg == ELEM_LAST)
                                    begin
                                        det_mode_next = 1'b1;
                                        det_next      = '0;
                                    end
                                end
                                else
                                    t_next = t_reg + 2'd1;
                            end
                        endcase
                    end
                end
            end
            ST_DETFIN:
            begin
                dneg_next    = det_reg[ACCW-1];
                dmag_next    = det_reg[ACCW-1] ? '0 - det_reg : det_reg;
                sing_next    = (det_reg == '0);
                det_sat_next = dq_sat;
                if (dq_sat)
                    det_out_next = {dq[ACCW-1], {(DW-1){!dq[ACCW-1]}}};
                else
                    det_out_next = dq[DW-1:0];
                det_mode_next = 1'b0;
                k_next        = '0;
                state_next    = ST_QRD;
            end
            ST_QRD:
                state_next = ST_QSTART;
            ST_QSTART:
            begin
                qneg_next = adj_rd_reg[AW-1] ^ dneg_reg;
                if (sing_reg)
                begin
                    inv_next       = '0;
                    idx_next       = k_reg;
                    ovf_next       = det_sat_reg;
                    last_next      = (k_reg == ELEM_LAST);
                    out_valid_next = 1'b1;
                    state_next     = ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_QWAIT;
                end
            end
            ST_QWAIT:
            begin
                if (div_done)
                begin
                    if (q_sat)
                        inv_next = {qneg_reg, {(W-1){!qneg_reg}}};
                    else if (qneg_reg)
                        inv_next = '0 - quot[W-1:0];
                    else
                        inv_next = quot[W-1:0];
                    idx_next       = k_reg;
                    ovf_next       = q_sat | det_sat_reg;
                    last_next      = (k_reg == ELEM_LAST);
                    out_valid_next = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    out_valid_next = 1'b0;
                    k_next         = k_reg + 4'd1;
                    if (k_reg == ELEM_LAST)
                    begin
                        det_mode_next = 1'b0;
                        state_next    = ST_LOAD;
                    end
                    else
                        state_next = ST_QRD;
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            k_reg         <= '0;
            t_reg         <= '0;
            ph_reg        <= PH_MINOR_A;
            det_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            k_reg         <= k_next;
            t_reg         <= t_next;
            ph_reg        <= ph_next;
            det_mode_reg  <= det_mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc2_reg    <= acc2_next;
        acc3_reg    <= acc3_next;
        det_reg     <= det_next;
        dmag_reg    <= dmag_next;
        dneg_reg    <= dneg_next;
        sing_reg    <= sing_next;
        det_out_reg <= det_out_next;
        det_sat_reg <= det_sat_next;
        qneg_reg    <= qneg_next;
        inv_reg     <= inv_next;
        idx_reg     <= idx_next;
        ovf_reg     <= ovf_next;
        last_reg    <= last_next;
    end

    assign result.valid             = out_valid_reg;
    assign result.inverse_value     = inv_reg;
    assign result.element_index     = idx_reg;
    assign result.determinant_value = det_out_reg;
    assign result.singular_flag     = sing_reg;
    assign result.overflow_flag     = ovf_reg;
    assign result.last_flag         = last_reg;

`ifndef SYNTHESIS
    a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> state_reg == ST_OUT)
        else $error("result valid outside output state");
    a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        element.ready |-> !result.valid)
        else $error("loading while a result is pending");
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.singular_flag |->
            result.inverse_value == '0 && !result.overflow_flag)
        else $error("singular result not zero");
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && result.last_flag |=> state_reg == ST_LOAD)
        else $error("no return to loading after last word");
`endif

endmodule
